// ===== rtl/mnrs_pkg.sv =====
`default_nettype none

package mnrs_pkg;

	typedef enum logic [2:0] {
		MODE_EVAL     = 3'd0,
		MODE_UNROUTED = 3'd1,
		MODE_UPLINK   = 3'd2,
		MODE_NB_WRITE = 3'd3,
		MODE_RT_WRITE = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ROLE_LEAF     = 2'd0,
		ROLE_ROUTER   = 2'd1,
		ROLE_BACKHAUL = 2'd2
	} role_t;

	typedef enum logic [2:0] {
		WHY_NONE        = 3'd0,
		WHY_UPLINK_UP   = 3'd1,
		WHY_UPLINK_DOWN = 3'd2,
		WHY_UNROUTED    = 3'd3,
		WHY_FEW         = 3'd4,
		WHY_ENOUGH      = 3'd5
	} reason_t;

	typedef enum logic [1:0] {
		CFG_STARTED  = 2'd0,
		CFG_DENSITY  = 2'd1,
		CFG_DWELL    = 2'd2,
		CFG_LIFETIME = 2'd3
	} cfg_idx_t;

	localparam logic [5:0]  DENSITY_RST  = 6'd2;
	localparam logic [31:0] DWELL_RST    = 32'd15000000;
	localparam logic [31:0] LIFETIME_RST = 32'd20000000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] now_us;
		logic        has_route;
		logic        uplink_req;
		logic [5:0]  slot_index;
		logic        entry_valid;
		logic        peer_is_leaf;
		logic        peer_rank_unknown;
		logic [63:0] route_expiry_us;
	} item_t;

	typedef struct packed {
		logic [1:0] role;
		logic       role_changed;
		logic [2:0] change_reason;
		logic [5:0] router_count;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    exec;
		logic    prep;
		logic    take;
		role_t   want;
		reason_t why;
		logic    scan_clr;
		logic    scan_run;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  uplink_chg;
		logic  started;
		logic  uplink;
		role_t role;
		logic  own_route;
		logic  dwell_blk;
		logic  unr_near;
		logic  few;
		logic  enough;
		logic  child;
		logic  scan_end;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mnrs_ram.sv =====
`default_nettype none

module mnrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mnrs_ctrl.sv =====
`default_nettype none

module mnrs_ctrl
	import mnrs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PREP,
		S_DECIDE,
		S_SCAN
	} state_t;

	state_t state_q, state_d;
	logic   done_q, finish;

	always_comb begin
		cmd      = '0;
		cmd.want = ROLE_LEAF;
		cmd.why  = WHY_NONE;
		state_d  = state_q;
		finish   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.mode == MODE_EVAL ||
				    (stat.mode == MODE_UPLINK && stat.uplink_chg && stat.started)) begin
					state_d = S_PREP;
				end else begin
					finish = 1'b1;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				finish = 1'b1;
				if (!stat.started) begin
					finish = 1'b1;
				end else if (stat.uplink) begin
					cmd.take = 1'b1;
					cmd.want = ROLE_BACKHAUL;
					cmd.why  = WHY_UPLINK_UP;
				end else if (stat.role == ROLE_BACKHAUL) begin
					cmd.take = 1'b1;
					cmd.want = ROLE_ROUTER;
					cmd.why  = WHY_UPLINK_DOWN;
				end else if (stat.dwell_blk) begin
					finish = 1'b1;
				end else if (stat.role == ROLE_LEAF) begin
					if (stat.own_route && stat.unr_near) begin
						cmd.take = 1'b1;
						cmd.want = ROLE_ROUTER;
						cmd.why  = WHY_UNROUTED;
					end else if (stat.own_route && stat.few) begin
						cmd.take = 1'b1;
						cmd.want = ROLE_ROUTER;
						cmd.why  = WHY_FEW;
					end
				end else if (!stat.unr_near && stat.enough) begin
					// demotion only if no live child route remains
					finish       = 1'b0;
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.child) begin
					finish = 1'b1;
				end else if (stat.scan_end) begin
					cmd.take = 1'b1;
					cmd.want = ROLE_LEAF;
					cmd.why  = WHY_ENOUGH;
					finish   = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/mnrs_dp.sv =====
`default_nettype none

module mnrs_dp
	import mnrs_pkg::*;
#(
	parameter int NEIGHBOUR_SLOTS = 32,
	parameter int ROUTE_SLOTS     = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire item_t       item,
	input  wire dp_cmd_t     cmd,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output dp_stat_t         stat,
	output result_t          result
);

	localparam int NW = (NEIGHBOUR_SLOTS > 1) ? $clog2(NEIGHBOUR_SLOTS) : 1;
	localparam int CW = $clog2(NEIGHBOUR_SLOTS + 1);
	localparam int AW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam int SW = $clog2(ROUTE_SLOTS + 1);
	localparam logic [6:0]    NB_LIMIT = 7'(NEIGHBOUR_SLOTS);
	localparam logic [6:0]    RT_LIMIT = 7'(ROUTE_SLOTS);
	localparam logic [SW-1:0] SCAN_END = SW'(ROUTE_SLOTS);

	// configuration
	logic        started_q;
	logic [5:0]  density_q;
	logic [31:0] dwell_q;
	logic [31:0] lifetime_q;

	// node state
	item_t                item_q;
	role_t                role_q;
	reason_t              reason_q;
	logic                 uplink_q;
	logic [63:0]          last_q;
	logic [63:0]          seen_q;
	logic [NEIGHBOUR_SLOTS-1:0] nb_q;
	logic [CW-1:0]        count_q;
	logic [ROUTE_SLOTS-1:0] live_q;

	// evaluation flags
	logic dwell_blk_q, unr_near_q, few_q, enough_q;

	// route scan
	logic [SW-1:0] scan_q;
	logic          pend_s1;
	logic          rd_en;
	logic [63:0]   rd_data;

	logic [NW-1:0] nb_idx;
	logic          nb_new, nb_old, nb_ok, rt_ok, rt_we;
	mode_t         mode;

	assign mode   = mode_t'(item_q.mode);
	assign nb_idx = item_q.slot_index[NW-1:0];
	assign nb_ok  = ({1'b0, item_q.slot_index} < NB_LIMIT);
	assign rt_ok  = ({1'b0, item_q.slot_index} < RT_LIMIT);
	assign nb_new = item_q.entry_valid & ~item_q.peer_is_leaf & ~item_q.peer_rank_unknown;
	assign nb_old = nb_q[nb_idx];
	assign rt_we  = cmd.exec && (mode == MODE_RT_WRITE) && rt_ok;
	assign rd_en  = cmd.scan_run && (scan_q != SCAN_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			density_q  <= DENSITY_RST;
			dwell_q    <= DWELL_RST;
			lifetime_q <= LIFETIME_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STARTED:  started_q  <= cfg_data[0];
				CFG_DENSITY:  density_q  <= cfg_data[5:0];
				CFG_DWELL:    dwell_q    <= cfg_data;
				CFG_LIFETIME: lifetime_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.prep) begin
			dwell_blk_q <= (last_q != 64'd0) &&
			               ((item_q.now_us - last_q) < {32'd0, dwell_q});
			unr_near_q  <= (seen_q != 64'd0) &&
			               ((item_q.now_us - seen_q) < {32'd0, lifetime_q});
			few_q       <= (7'(count_q) < {1'b0, density_q});
			enough_q    <= (7'(count_q) > {1'b0, density_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q   <= ROLE_LEAF;
			reason_q <= WHY_NONE;
			uplink_q <= 1'b0;
			last_q   <= 64'd0;
			seen_q   <= 64'd0;
			nb_q     <= '0;
			count_q  <= '0;
			live_q   <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
		end else begin
			if (cmd.load) begin
				reason_q <= WHY_NONE;
			end
			if (cmd.exec) begin
				case (mode)
					MODE_UNROUTED: begin
						seen_q <= item_q.now_us;
					end
					MODE_UPLINK: begin
						if (item_q.uplink_req != uplink_q) begin
							uplink_q <= item_q.uplink_req;
							if (started_q) begin
								last_q <= 64'd0;
							end
						end
					end
					MODE_NB_WRITE: begin
						if (nb_ok) begin
							nb_q[nb_idx] <= nb_new;
							if (nb_new && !nb_old) begin
								count_q <= count_q + CW'(1);
							end else if (!nb_new && nb_old) begin
								count_q <= count_q - CW'(1);
							end
						end
					end
					MODE_RT_WRITE: begin
						if (rt_ok) begin
							live_q[item_q.slot_index[AW-1:0]] <= item_q.entry_valid;
						end
					end
					default: ;
				endcase
			end
			if (cmd.take && (cmd.want != role_q)) begin
				role_q   <= cmd.want;
				last_q   <= item_q.now_us;
				reason_q <= cmd.why;
			end
			if (cmd.scan_clr) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				if (rd_en) begin
					pend_s1 <= live_q[scan_q[AW-1:0]];
					scan_q  <= scan_q + SW'(1);
				end else begin
					pend_s1 <= 1'b0;
				end
			end
		end
	end

	mnrs_ram #(
		.WIDTH (64),
		.DEPTH (ROUTE_SLOTS),
		.AW    (AW)
	) u_expiry (
		.clk   (clk),
		.we    (rt_we),
		.waddr (item_q.slot_index[AW-1:0]),
		.wdata (item_q.route_expiry_us),
		.re    (rd_en),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		stat.mode       = mode;
		stat.uplink_chg = (item_q.uplink_req != uplink_q);
		stat.started    = started_q;
		stat.uplink     = uplink_q;
		stat.role       = role_q;
		stat.own_route  = item_q.has_route;
		stat.dwell_blk  = dwell_blk_q;
		stat.unr_near   = unr_near_q;
		stat.few        = few_q;
		stat.enough     = enough_q;
		stat.child      = pend_s1 && (rd_data > item_q.now_us);
		stat.scan_end   = (scan_q == SCAN_END) && !pend_s1;
	end

	always_comb begin
		result.role          = role_q;
		result.role_changed  = (reason_q != WHY_NONE);
		result.change_reason = reason_q;
		result.router_count  = 6'(count_q);
	end

endmodule

`default_nettype wire

// ===== rtl/mesh_node_role_selector.sv =====
`default_nettype none

// Mesh node role selector. An item is taken when start is high and busy is low;
// its single result appears on result for one cycle with done high and must be
// captured then, the receiver cannot stall it. Table writes, unrouted notes and
// set-uplink items that change nothing, or that reach a stopped node, end in the
// execute state; an evaluation, or an uplink change on a started node, goes on
// through the prepare and decide states; an evaluation that may demote a router
// to leaf also scans the route expiry RAM one slot per cycle. The scan through
// that RAM's single read port sets the worst case. The router count is kept as
// a running total, so no counting pass is needed. Configuration writes are
// taken whenever busy is low (cfg_ready); no clearing pass follows reset.
module mesh_node_role_selector
	import mnrs_pkg::*;
#(
	parameter int NEIGHBOUR_SLOTS = 32,
	parameter int ROUTE_SLOTS     = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             done,
	output result_t          result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = ~busy;

	mnrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mnrs_dp #(
		.NEIGHBOUR_SLOTS (NEIGHBOUR_SLOTS),
		.ROUTE_SLOTS     (ROUTE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== dv/mnrs_role_checker.sv =====
`timescale 1ns / 100ps

module mnrs_role_checker
	import mnrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        done,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          changes
);
	localparam int NB_SLOTS = 32;
	localparam int RT_SLOTS = 64;

	logic                run_en;
	logic [5:0]          density;
	logic [31:0]         dwell;
	logic [31:0]         lifetime;
	role_t               role;
	logic                uplink;
	logic [63:0]         last_change;
	logic [63:0]         unrouted_at;
	logic [NB_SLOTS-1:0] nb_routed;
	logic [RT_SLOTS-1:0] rt_live;
	logic [63:0]         rt_expiry [RT_SLOTS];
	result_t             role_due [$];

	function automatic reason_t adopt(role_t want, reason_t why, logic [63:0] now);
		if (want == role)
			return WHY_NONE;
		role = want;
		last_change = now;
		return why;
	endfunction

	// zero stamp means never heard
	function automatic logic unrouted_near(logic [63:0] now);
		return unrouted_at != 0 && (now - unrouted_at) < {32'd0, lifetime};
	endfunction

	function automatic logic has_child(logic [63:0] now);
		for (int i = 0; i < RT_SLOTS; i++)
			if (rt_live[i] && rt_expiry[i] > now)
				return 1'b1;
		return 1'b0;
	endfunction

	// override, then dwell, then router-count hysteresis
	function automatic reason_t settle_role(logic [63:0] now, logic own_route);
		int routers;
		if (!run_en)
			return WHY_NONE;
		if (uplink)
			return adopt(ROLE_BACKHAUL, WHY_UPLINK_UP, now);
		if (role == ROLE_BACKHAUL)
			return adopt(ROLE_ROUTER, WHY_UPLINK_DOWN, now);
		if (last_change != 0 && (now - last_change) < {32'd0, dwell})
			return WHY_NONE;
		routers = $countones(nb_routed);
		if (role == ROLE_LEAF) begin
			if (!own_route)
				return WHY_NONE;
			if (unrouted_near(now))
				return adopt(ROLE_ROUTER, WHY_UNROUTED, now);
			if (routers < density)
				return adopt(ROLE_ROUTER, WHY_FEW, now);
			return WHY_NONE;
		end
		if (has_child(now) || unrouted_near(now))
			return WHY_NONE;
		if (routers > density)
			return adopt(ROLE_LEAF, WHY_ENOUGH, now);
		return WHY_NONE;
	endfunction

	function automatic result_t predict_role_item(item_t it);
		result_t r;
		reason_t why;
		why = WHY_NONE;
		case (it.mode)
			MODE_EVAL: why = settle_role(it.now_us, it.has_route);
			MODE_UNROUTED: unrouted_at = it.now_us;
			MODE_UPLINK: if (uplink != it.uplink_req) begin
				uplink = it.uplink_req;
				if (run_en) begin
					last_change = '0;
					why = settle_role(it.now_us, it.has_route);
				end
			end
			MODE_NB_WRITE: if (it.slot_index < NB_SLOTS)
				nb_routed[it.slot_index] = it.entry_valid && !it.peer_is_leaf
					&& !it.peer_rank_unknown;
			MODE_RT_WRITE: if (it.slot_index < RT_SLOTS) begin
				rt_live[it.slot_index] = it.entry_valid;
				rt_expiry[it.slot_index] = it.route_expiry_us;
			end
			default: ;
		endcase
		r.role = role;
		r.role_changed = why != WHY_NONE;
		r.change_reason = why;
		r.router_count = 6'($countones(nb_routed));
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t due;
		if (!arst_n) begin
			run_en = 1'b0;
			density = DENSITY_RST;
			dwell = DWELL_RST;
			lifetime = LIFETIME_RST;
			role = ROLE_LEAF;
			uplink = 1'b0;
			last_change = '0;
			unrouted_at = '0;
			nb_routed = '0;
			rt_live = '0;
			role_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_idx_t'(cfg_index))
					CFG_STARTED: run_en = cfg_data[0];
					CFG_DENSITY: density = cfg_data[5:0];
					CFG_DWELL: dwell = cfg_data;
					CFG_LIFETIME: lifetime = cfg_data;
				endcase
			if (done) begin
				if (role_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: role %0d changed %0d reason %0d routers %0d",
						$time, result.role, result.role_changed, result.change_reason,
						result.router_count);
				end else begin
					due = role_due.pop_front();
					check_field("role", due.role, result.role);
					check_field("role_changed", due.role_changed, result.role_changed);
					check_field("change_reason", due.change_reason, result.change_reason);
					check_field("router_count", due.router_count, result.router_count);
					checked++;
					if (due.role_changed)
						changes++;
				end
			end
			// transaction accepted: predict against the state as it stands now
			if (start && !busy)
				role_due.push_back(predict_role_item(item));
			pending = role_due.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import mnrs_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_STARTED;
	logic [31:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          checked;
	int          changes;
	int          sent = 0;
	int          cycles = 0;
	int          idle_pct = 29;
	logic [63:0] t_us = '0;

	always #5 clk = ~clk;

	mesh_node_role_selector u_top (.*);

	mnrs_role_checker u_chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called at a falling edge; start stays high when no gap follows
	task automatic push(input item_t it);
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 80)) @(negedge clk);
			else
				repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic run, input logic [5:0] dens, input logic [31:0] dw,
			input logic [31:0] life);
		write_reg(CFG_STARTED, {31'd0, run});
		write_reg(CFG_DENSITY, {26'd0, dens});
		write_reg(CFG_DWELL, dw);
		write_reg(CFG_LIFETIME, life);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t cmd(mode_t m, logic [63:0] now, logic own = 1'b1,
			logic up = 1'b0);
		item_t it;
		it = '0;
		it.mode = m;
		it.now_us = now;
		it.has_route = own;
		it.uplink_req = up;
		return it;
	endfunction

	function automatic item_t nb_cmd(logic [5:0] slot, logic valid, logic leaf,
			logic unknown, logic [63:0] now);
		item_t it;
		it = cmd(MODE_NB_WRITE, now);
		it.slot_index = slot;
		it.entry_valid = valid;
		it.peer_is_leaf = leaf;
		it.peer_rank_unknown = unknown;
		return it;
	endfunction

	function automatic item_t rt_cmd(logic [5:0] slot, logic valid, logic [63:0] expiry,
			logic [63:0] now);
		item_t it;
		it = cmd(MODE_RT_WRITE, now);
		it.slot_index = slot;
		it.entry_valid = valid;
		it.route_expiry_us = expiry;
		return it;
	endfunction

	// time mostly creeps forward around the dwell and lifetime scale, with rare jumps
	function automatic item_t rand_item();
		item_t it;
		int pick;
		case ($urandom_range(19))
			0: t_us = {$urandom, $urandom};
			1, 2: t_us += {32'd0, $urandom};
			3, 4, 5, 6, 7, 8, 9: t_us += $urandom_range(40_000_000);
			default: t_us += $urandom_range(3_000_000);
		endcase
		it.now_us = ($urandom_range(99) < 2) ? 64'd0 : t_us;
		it.has_route = $urandom_range(99) < 75;
		it.uplink_req = $urandom_range(99) < 25;
		it.entry_valid = $urandom_range(99) < 70;
		it.peer_is_leaf = $urandom_range(99) < 20;
		it.peer_rank_unknown = $urandom_range(99) < 20;
		case ($urandom_range(9))
			0, 1: it.slot_index = 6'($urandom_range(32, 63));
			2, 3: it.slot_index = 6'($urandom_range(31));
			default: it.slot_index = 6'($urandom_range(7));
		endcase
		case ($urandom_range(9))
			0: it.route_expiry_us = {$urandom, $urandom};
			1: it.route_expiry_us = $urandom_range(1) ? '1 : '0;
			2, 3, 4: it.route_expiry_us = t_us - $urandom_range(40_000_000);
			default: it.route_expiry_us = t_us + $urandom_range(40_000_000);
		endcase
		pick = $urandom_range(99);
		if (pick < 38)
			it.mode = MODE_EVAL;
		else if (pick < 48)
			it.mode = MODE_UNROUTED;
		else if (pick < 58)
			it.mode = MODE_UPLINK;
		else if (pick < 80)
			it.mode = MODE_NB_WRITE;
		else if (pick < 95)
			it.mode = MODE_RT_WRITE;
		else
			it.mode = 3'($urandom_range(5, 7));
		return it;
	endfunction

	initial begin
		logic [63:0] t;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the expiry RAM so the child scan never reads an unwritten entry
		for (int s = 0; s < 64; s++)
			push(rt_cmd(6'(s), 1'b0, {$urandom, $urandom}, 64'd0));

		// stopped node: evaluation idle, uplink flag still follows
		push(cmd(MODE_EVAL, 64'd1000));
		push(cmd(MODE_UPLINK, 64'd2000, 1'b1, 1'b1));
		push(cmd(MODE_UPLINK, 64'd3000, 1'b1, 1'b0));
		drain();
		set_regs(1'b1, DENSITY_RST, DWELL_RST, LIFETIME_RST);

		t = 64'd5_000_000;
		push(cmd(MODE_EVAL, t, 1'b0));
		push(cmd(MODE_EVAL, t));
		push(nb_cmd(6'd0, 1'b1, 1'b0, 1'b0, t));
		push(nb_cmd(6'd1, 1'b1, 1'b0, 1'b0, t));
		push(nb_cmd(6'd2, 1'b1, 1'b0, 1'b0, t));
		push(nb_cmd(6'd3, 1'b1, 1'b1, 1'b0, t));
		push(nb_cmd(6'd4, 1'b1, 1'b0, 1'b1, t));
		push(nb_cmd(6'd40, 1'b1, 1'b0, 1'b0, t));
		push(cmd(MODE_EVAL, t + 1_000_000));
		t += 16_000_000;
		push(rt_cmd(6'd63, 1'b1, '1, t));
		push(cmd(MODE_EVAL, t));
		push(rt_cmd(6'd63, 1'b0, '0, t));
		push(cmd(MODE_UNROUTED, t));
		push(cmd(MODE_EVAL, t + 1));
		t += 25_000_000;
		push(cmd(MODE_EVAL, t));
		push(cmd(MODE_UNROUTED, t + 15_500_000));
		push(cmd(MODE_EVAL, t + 16_000_000));
		push(cmd(MODE_UPLINK, t + 16_000_001, 1'b1, 1'b1));
		push(cmd(MODE_EVAL, t + 16_000_002));
		push(cmd(MODE_UPLINK, t + 16_000_003, 1'b1, 1'b0));
		push(item_t'('1));
		push(cmd(MODE_UNROUTED, 64'd0));
		t_us = t;

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: set_regs(1'b1, 6'd0, 32'd0, 32'd0);
				1: set_regs(1'b1, 6'd32, '1, '1);
				2: set_regs(1'b1, 6'($urandom_range(8)), $urandom_range(20_000_000),
					$urandom_range(30_000_000));
				3: set_regs(1'b0, 6'($urandom_range(32)), $urandom, $urandom);
				default: set_regs(1'b1, 6'($urandom_range(1, 6)),
					$urandom_range(1_000_000, 10_000_000),
					$urandom_range(5_000_000, 40_000_000));
			endcase
			repeat (ph == 3 ? 60 : 170) begin
				idle_pct = (sent < 300) ? 29 : (sent < 560) ? 68 : 0;
				push(rand_item());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d transactions across seven register settings, stopped and running",
			sent);
		$display("%0d results checked, %0d of them role changes", checked, changes);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== mesh_node_role_selector.f =====
rtl/mnrs_pkg.sv
rtl/mnrs_ram.sv
rtl/mnrs_ctrl.sv
rtl/mnrs_dp.sv
rtl/mesh_node_role_selector.sv
dv/mnrs_role_checker.sv
dv/tb.sv
